>>> rtl/rc4_pkg.sv
// Shared constants, operation codes and the permutation store request type for the RC4 block.
package rc4_pkg;

    // Default key store depth
    localparam int KEY_DEPTH_DEF = 256;

    // Permutation size and byte width
    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;

    // Key length register
    localparam int           KEY_LEN_W   = 9;
    localparam logic [8:0]   KEY_LEN_RST = 9'd16;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Operation codes
    localparam logic [1:0] OP_KEY_WR = 2'd0;
    localparam logic [1:0] OP_KSA    = 2'd1;
    localparam logic [1:0] OP_CRYPT  = 2'd2;

    typedef logic [BYTE_W-1:0] byte_t;

    // One cycle's access to the permutation store
    typedef struct packed {
        logic  clear;   // back to identity
        logic  re;
        byte_t raddr;
        logic  we;
        byte_t waddr;
        byte_t wdata;
    } sbox_req_t;

endpackage

>>> rtl/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rc4_sbox.sv
// Permutation store: RAM plus per-entry valid bits so that unwritten entries read as identity.
module rc4_sbox (
    input  logic               aclk,
    input  logic               aresetn,
    input  rc4_pkg::sbox_req_t req,
    output rc4_pkg::byte_t     rdata
);

    logic [rc4_pkg::SBOX_DEPTH-1:0] vld_reg;
    rc4_pkg::byte_t                 raddr_reg;
    logic                           rvld_reg;
    rc4_pkg::byte_t                 ram_rdata;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (ram_rdata)
    );

    // Valid bits: cleared by reset or a new key schedule, set by writes
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            vld_reg <= '0;
        end else if (req.we) begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    // Track read address and its valid bit alongside the RAM read
    always_ff @(posedge aclk) begin
        if (req.re) begin
            raddr_reg <= req.raddr;
            rvld_reg  <= vld_reg[req.raddr];
        end
    end

    // Unwritten entry holds its own index
    assign rdata = rvld_reg ? ram_rdata : raddr_reg;

`ifndef ASSERT_OFF
    a_clear_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        req.clear |-> !req.we)
        else $error("permutation write during clear");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        req.clear |=> (vld_reg == '0))
        else $error("valid bits not cleared");

    a_write_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.we && !req.clear) |=> vld_reg[$past(req.waddr)])
        else $error("written entry not marked valid");
`endif

endmodule

>>> rtl/rc4_ctrl.sv
// Sequencer: key writes, key schedule and per-byte crypt over the permutation store.
module rc4_ctrl #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF,
    localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rc4_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rc4_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    // effective key length, 1..KEY_DEPTH
    input  logic [rc4_pkg::KEY_LEN_W-1:0]    key_len,
    // key store
    output logic                             key_we,
    output logic [KEY_AW-1:0]                key_waddr,
    output rc4_pkg::byte_t                   key_wdata,
    output logic                             key_re,
    output logic [KEY_AW-1:0]                key_raddr,
    input  rc4_pkg::byte_t                   key_rdata,
    // permutation store
    output rc4_pkg::sbox_req_t               sbox_req,
    input  rc4_pkg::byte_t                   sbox_rdata
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CR_J    = 4'd1;
    localparam logic [3:0] ST_CR_SWAP = 4'd2;
    localparam logic [3:0] ST_CR_OUT  = 4'd3;
    localparam logic [3:0] ST_KS_RD   = 4'd4;
    localparam logic [3:0] ST_KS_ACC  = 4'd5;
    localparam logic [3:0] ST_KS_WN   = 4'd6;
    localparam logic [3:0] ST_KS_WA   = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_DEPTH_W = rc4_pkg::KEY_LEN_W'(KEY_DEPTH);

    logic [3:0]        state_reg, state_next;
    rc4_pkg::byte_t    i_reg, i_next;
    rc4_pkg::byte_t    j_reg, j_next;
    rc4_pkg::byte_t    a_reg, a_next;
    rc4_pkg::byte_t    c_reg, c_next;
    rc4_pkg::byte_t    t_reg, t_next;
    rc4_pkg::byte_t    data_reg, data_next;
    rc4_pkg::byte_t    res_reg, res_next;
    logic              last_reg, last_next;
    logic [KEY_AW-1:0] kpos_reg, kpos_next;
    logic              m_tvalid_reg, m_tvalid_next;
    rc4_pkg::byte_t    m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;

    logic           accept;
    logic [1:0]     in_op;
    rc4_pkg::byte_t in_idx;
    rc4_pkg::byte_t in_data;
    rc4_pkg::byte_t acc;
    rc4_pkg::byte_t tsum;
    rc4_pkg::byte_t ks;
    logic [rc4_pkg::KEY_LEN_W-1:0] kpos_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = s_tdata[1:0];
    assign in_idx   = s_tdata[9:2];
    assign in_data  = s_tdata[17:10];

    // Key schedule running sum, crypt keystream index and key position step
    assign acc      = rc4_pkg::BYTE_W'(j_reg + key_rdata + sbox_rdata);
    assign tsum     = rc4_pkg::BYTE_W'(a_reg + sbox_rdata);
    assign kpos_inc = rc4_pkg::KEY_LEN_W'(kpos_reg) + 1'b1;

    // Keystream byte: forward the two swap writes that may not have reached the store
    always_comb begin
        if (t_reg == j_reg) begin
            ks = a_reg;
        end else if (t_reg == i_reg) begin
            ks = c_reg;
        end else begin
            ks = sbox_rdata;
        end
    end

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        a_next        = a_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        data_next     = data_reg;
        res_next      = res_reg;
        last_next     = last_reg;
        kpos_next     = kpos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        sbox_req      = '0;
        key_we        = 1'b0;
        key_waddr     = in_idx[KEY_AW-1:0];
        key_wdata     = in_data;
        key_re        = 1'b0;
        key_raddr     = kpos_reg;

        // Result register empties on its transfer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    data_next = in_data;
                    last_next = s_tlast;
                    res_next  = '0;
                    case (in_op)
                        rc4_pkg::OP_KEY_WR: begin
                            key_we     = ({1'b0, in_idx} < KEY_DEPTH_W);
                            state_next = ST_DONE;
                        end
                        rc4_pkg::OP_KSA: begin
                            sbox_req.clear = 1'b1;
                            i_next         = '0;
                            j_next         = '0;
                            kpos_next      = '0;
                            state_next     = ST_KS_RD;
                        end
                        rc4_pkg::OP_CRYPT: begin
                            i_next         = i_reg + 1'b1;
                            sbox_req.re    = 1'b1;
                            sbox_req.raddr = i_reg + 1'b1;
                            state_next     = ST_CR_J;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // a = S[i]; j += a; read S[j]
            ST_CR_J: begin
                a_next         = sbox_rdata;
                j_next         = j_reg + sbox_rdata;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = j_reg + sbox_rdata;
                state_next     = ST_CR_SWAP;
            end
            // c = S[j]; S[i] = c; read S[a + c]
            ST_CR_SWAP: begin
                c_next         = sbox_rdata;
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = tsum;
                t_next         = tsum;
                state_next     = ST_CR_OUT;
            end
            // S[j] = a; combine keystream byte
            ST_CR_OUT: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = a_reg;
                res_next       = data_reg ^ ks;
                state_next     = ST_DONE;
            end
            // Key schedule step: read S[n] and key byte
            ST_KS_RD: begin
                sbox_req.re    = 1'b1;
                sbox_req.raddr = i_reg;
                key_re         = 1'b1;
                state_next     = ST_KS_ACC;
            end
            // acc += key + S[n]; read S[acc]
            ST_KS_ACC: begin
                a_next         = sbox_rdata;
                j_next         = acc;
                sbox_req.re    = 1'b1;
                sbox_req.raddr = acc;
                state_next     = ST_KS_WN;
            end
            // S[n] = S[acc]
            ST_KS_WN: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = i_reg;
                sbox_req.wdata = sbox_rdata;
                state_next     = ST_KS_WA;
            end
            // S[acc] = old S[n]; advance
            ST_KS_WA: begin
                sbox_req.we    = 1'b1;
                sbox_req.waddr = j_reg;
                sbox_req.wdata = a_reg;
                i_next         = i_reg + 1'b1;
                if (kpos_inc >= key_len) begin
                    kpos_next = '0;
                end else begin
                    kpos_next = kpos_inc[KEY_AW-1:0];
                end
                if (i_reg == 8'hFF) begin
                    j_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_KS_RD;
                end
            end
            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tlast_next  = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        c_reg       <= c_next;
        t_reg       <= t_next;
        data_reg    <= data_next;
        res_reg     <= res_next;
        last_reg    <= last_next;
        kpos_reg    <= kpos_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    a_ks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_WA && i_reg == 8'hFF)
        |=> (i_reg == 8'h00 && j_reg == 8'h00 && state_reg == ST_DONE))
        else $error("key schedule did not end with cleared pointers");

    a_kpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_RD) |-> (rc4_pkg::KEY_LEN_W'(kpos_reg) < key_len))
        else $error("key position beyond key length");

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sbox_req.clear |-> (state_reg == ST_IDLE && accept))
        else $error("permutation clear outside an accepted key schedule");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("new transfer taken before result produced");
`endif

endmodule

>>> rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: key length register, key store and sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  config   | in  | cfg_wr_en          | cfg_wr_data[8:0] key_length
//  s_       | in  | s_tvalid/s_tready  | s_tdata: operation, key_index, data_byte; s_tlast
//  m_       | out | m_tvalid/m_tready  | m_tdata: data_out; m_tlast
//
// The key schedule makes four permutation accesses per swap step, over 256 steps.
// One item is in flight at a time; the next transfer is taken once the result
// sits in the output register, which holds it while m_tready is low.
// Reset (aresetn low, synchronous) restores the identity permutation at once
// through per-entry valid bits; key store contents are undefined until written.
module rc4_stream_cipher #(
    parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF,
    localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_wr_data,   // key_length
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rc4_pkg::S_TDATA_W-1:0] s_tdata,       // [1:0] operation, [9:2] key_index,
                                                          // [17:10] data_byte, [23:18] zero
    input  logic                          s_tlast,       // last_in
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rc4_pkg::M_TDATA_W-1:0] m_tdata,       // [7:0] data_out
    output logic                          m_tlast        // last_out
);

    localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_DEPTH_W = rc4_pkg::KEY_LEN_W'(KEY_DEPTH);

    logic [rc4_pkg::KEY_LEN_W-1:0] key_len_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0] key_len_eff;

    logic               key_we;
    logic [KEY_AW-1:0]  key_waddr;
    rc4_pkg::byte_t     key_wdata;
    logic               key_re;
    logic [KEY_AW-1:0]  key_raddr;
    rc4_pkg::byte_t     key_rdata;

    rc4_pkg::sbox_req_t sbox_req;
    rc4_pkg::byte_t     sbox_rdata;

    // Key length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= rc4_pkg::KEY_LEN_RST;
        end else if (cfg_wr_en) begin
            key_len_reg <= cfg_wr_data;
        end
    end

    // Zero means one; clamp to the key store depth
    always_comb begin
        if (key_len_reg == '0) begin
            key_len_eff = rc4_pkg::KEY_LEN_W'(1);
        end else if (key_len_reg > KEY_DEPTH_W) begin
            key_len_eff = KEY_DEPTH_W;
        end else begin
            key_len_eff = key_len_reg;
        end
    end

    rc4_ctrl #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .key_len    (key_len_eff),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_re     (key_re),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata),
        .sbox_req   (sbox_req),
        .sbox_rdata (sbox_rdata)
    );

    // Key store
    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Permutation store
    rc4_sbox u_sbox (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sbox_req),
        .rdata   (sbox_rdata)
    );

endmodule
